### rtl/core/ascon_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Ascon permutation core.
// Used by ascon_round, ascon_ctrl and ascon_permutation; depends on nothing.

package ascon_pkg;

	localparam int unsigned WordWidth  = 64;
	localparam int unsigned NumWords   = 5;
	localparam int unsigned RoundWidth = 4;

	// Round numbering follows the twelve-round schedule; the short form starts midway.
	localparam logic [RoundWidth-1:0] FirstRoundFull  = 4'd0;
	localparam logic [RoundWidth-1:0] FirstRoundShort = 4'd6;
	localparam logic [RoundWidth-1:0] LastRound       = 4'd11;

	// Request selector codes.
	localparam logic ReqFull  = 1'b0;
	localparam logic ReqShort = 1'b1;

	typedef logic [WordWidth-1:0] ascon_word_t;
	typedef ascon_word_t [NumWords-1:0] ascon_words_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} ascon_fsm_t;

	// Control group handed from the sequencer to the datapath.
	typedef struct packed {
		logic                  load;
		logic                  step;
		logic [RoundWidth-1:0] round_idx;
	} ascon_ctrl_t;

	// Round constant: upper nibble counts down from 15, lower nibble is the round number.
	function automatic logic [7:0] round_const(input logic [RoundWidth-1:0] idx);
		return {~idx, idx};
	endfunction

	// Right rotation of one state word by a fixed amount.
	function automatic ascon_word_t rotr(input ascon_word_t v, input logic [5:0] n);
		logic [2*WordWidth-1:0] dbl;
		dbl = {v, v} >> n;
		return dbl[WordWidth-1:0];
	endfunction

endpackage

### rtl/core/ascon_permutation.sv
`timescale 1ns / 1ps
// Ascon permutation core (twelve-round or six-round form) on a 320-bit state.
// Top level: holds the state register and ties ascon_ctrl to ascon_round (ascon_pkg).
//
// Usage:
//   The input channel carries req_type and the five state words; a beat is taken
//   when in_valid is high and in_stall is low. req_type low runs all twelve rounds,
//   req_type high runs only the last six.
//   The output channel carries the five permuted words; a beat is taken when
//   out_valid is high and out_stall is low.
//   One round is computed per clock by a single shared round unit, and the state
//   register steps through each round of the selected schedule. out_valid rises
//   once the last round has been written to the state register, and the result
//   beat can be taken in the same cycle that out_valid rises. One request is in
//   flight at a time; in_stall stays high from the input beat until the result
//   beat is taken, so a new request is accepted only after the previous result
//   beat has been taken.
//   While the receiver stalls, out_valid and the output words hold steady.
//   Reset (arst_n low) returns the sequencer to idle with no result pending; the
//   state words themselves are not cleared.

module ascon_permutation (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   req_type,
	input  ascon_pkg::ascon_word_t in_word0,
	input  ascon_pkg::ascon_word_t in_word1,
	input  ascon_pkg::ascon_word_t in_word2,
	input  ascon_pkg::ascon_word_t in_word3,
	input  ascon_pkg::ascon_word_t in_word4,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ascon_pkg::ascon_word_t out_word0,
	output ascon_pkg::ascon_word_t out_word1,
	output ascon_pkg::ascon_word_t out_word2,
	output ascon_pkg::ascon_word_t out_word3,
	output ascon_pkg::ascon_word_t out_word4
);

	ascon_pkg::ascon_ctrl_t  ctrl;
	ascon_pkg::ascon_words_t words_q;
	ascon_pkg::ascon_words_t round_out;

	ascon_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	ascon_round u_round (
		.words     (words_q),
		.round_idx (ctrl.round_idx),
		.result    (round_out)
	);

	// State register: loaded from the input beat, then updated once per round.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			words_q <= {in_word4, in_word3, in_word2, in_word1, in_word0};
		end else if (ctrl.step) begin
			words_q <= round_out;
		end
	end

	assign out_word0 = words_q[0];
	assign out_word1 = words_q[1];
	assign out_word2 = words_q[2];
	assign out_word3 = words_q[3];
	assign out_word4 = words_q[4];

`ifndef SYNTH
	// No new request is taken while a result is pending.
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input beat possible while a result is pending");

	// The round counter never runs past the last round while stepping.
	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step |-> (ctrl.round_idx <= ascon_pkg::LastRound))
		else $error("round index beyond the last round");

	// A short request starts at the midpoint of the schedule.
	a_short_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type) |=>
			(ctrl.step && ctrl.round_idx == ascon_pkg::FirstRoundShort))
		else $error("short request did not start at round six");

	// A full request starts at round zero.
	a_full_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !req_type) |=>
			(ctrl.step && ctrl.round_idx == ascon_pkg::FirstRoundFull))
		else $error("full request did not start at round zero");
`endif

endmodule

### rtl/core/ascon_round.sv
`timescale 1ns / 1ps
// One Ascon round: constant addition, 5-bit substitution layer and linear diffusion.
// Purely combinational; uses ascon_pkg for the word types and helper functions.

module ascon_round (
	input  ascon_pkg::ascon_words_t              words,
	input  logic [ascon_pkg::RoundWidth-1:0]     round_idx,
	output ascon_pkg::ascon_words_t              result
);

	ascon_pkg::ascon_word_t a0, a1, a2, a3, a4;
	ascon_pkg::ascon_word_t b0, b1, b2, b3, b4;
	ascon_pkg::ascon_word_t c0, c1, c2, c3, c4;
	ascon_pkg::ascon_word_t d0, d1, d2, d3, d4;

	// Constant addition and the input mixing of the substitution layer.
	always_comb begin
		a0 = words[0] ^ words[4];
		a1 = words[1];
		a2 = words[2] ^ {56'd0, ascon_pkg::round_const(round_idx)} ^ words[1];
		a3 = words[3];
		a4 = words[4] ^ words[3];
	end

	// Nonlinear chi step across the five bit slices.
	always_comb begin
		b0 = a0 ^ (~a1 & a2);
		b1 = a1 ^ (~a2 & a3);
		b2 = a2 ^ (~a3 & a4);
		b3 = a3 ^ (~a4 & a0);
		b4 = a4 ^ (~a0 & a1);
	end

	// Output mixing of the substitution layer.
	always_comb begin
		c0 = b0 ^ b4;
		c1 = b1 ^ b0;
		c2 = ~b2;
		c3 = b3 ^ b2;
		c4 = b4;
	end

	// Linear diffusion: each word XORed with two rotations of itself.
	always_comb begin
		d0 = c0 ^ ascon_pkg::rotr(c0, 6'd19) ^ ascon_pkg::rotr(c0, 6'd28);
		d1 = c1 ^ ascon_pkg::rotr(c1, 6'd61) ^ ascon_pkg::rotr(c1, 6'd39);
		d2 = c2 ^ ascon_pkg::rotr(c2, 6'd1)  ^ ascon_pkg::rotr(c2, 6'd6);
		d3 = c3 ^ ascon_pkg::rotr(c3, 6'd10) ^ ascon_pkg::rotr(c3, 6'd17);
		d4 = c4 ^ ascon_pkg::rotr(c4, 6'd7)  ^ ascon_pkg::rotr(c4, 6'd41);
	end

	assign result = {d4, d3, d2, d1, d0};

endmodule

### rtl/core/ascon_ctrl.sv
`timescale 1ns / 1ps
// Round sequencer for the Ascon permutation: accepts a request, counts rounds,
// and holds the result beat until taken. Uses ascon_pkg for states and the control struct.

module ascon_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   req_type,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ascon_pkg::ascon_ctrl_t ctrl
);

	ascon_pkg::ascon_fsm_t state_q, state_d;
	logic [ascon_pkg::RoundWidth-1:0] round_q, round_d;

	// State and round counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ascon_pkg::ST_IDLE;
			round_q <= ascon_pkg::FirstRoundFull;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

	// Next state and control outputs.
	always_comb begin
		state_d   = state_q;
		round_d   = round_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		ctrl      = '0;
		ctrl.round_idx = round_q;
		unique case (state_q)
			ascon_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = ascon_pkg::ST_RUN;
					round_d   = (req_type == ascon_pkg::ReqShort) ?
						ascon_pkg::FirstRoundShort : ascon_pkg::FirstRoundFull;
				end
			end
			ascon_pkg::ST_RUN: begin
				ctrl.step = 1'b1;
				round_d   = round_q + 4'd1;
				if (round_q == ascon_pkg::LastRound) begin
					state_d = ascon_pkg::ST_DONE;
				end
			end
			ascon_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ascon_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ascon_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
